// ===== rtl/circular_deque_top_defines.svh =====
// ----------------------------------------------------------------------------
// circular_deque_top_defines
// Assertion helpers used by the deque top level.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// same-cycle implication
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared widths, command and status codes, and types for the deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;

    typedef enum logic {
        ST_CMD,
        ST_LIST
    } cdq_state_t;

    typedef struct packed {
        logic listing;
        logic empty;
    } cdq_stat_t;

endpackage

// ===== rtl/cdq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels for deque commands and results.
// ----------------------------------------------------------------------------
interface cdq_cmd_if
    import cdq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_res_if
    import cdq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic                      last;

    modport source (output valid, output status, output read_value, output last,
                    input ready);
    modport sink   (input valid, input status, input read_value, input last,
                    output ready);
endinterface

// ===== rtl/cdq_ring_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ring_mem
// Ring storage: one write port, one read port, registered read data.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module cdq_ring_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [IDX_W-1:0]          waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic                      re,
    input  logic [IDX_W-1:0]          raddr,
    output logic signed [VALUE_W-1:0] rdata
);

    logic signed [VALUE_W-1:0] ring_mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ring_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Front/rear pointers, command decode, list sequencer and result register.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    cdq_cmd_if.sink                   in_ch,
    cdq_res_if.source                 out_ch,
    input  logic [CAP_W-1:0]          cap,
    input  logic                      cfg_clear,
    output logic                      mem_we,
    output logic [IDX_W-1:0]          mem_waddr,
    output logic signed [VALUE_W-1:0] mem_wdata,
    output logic                      mem_re,
    output logic [IDX_W-1:0]          mem_raddr,
    input  logic signed [VALUE_W-1:0] mem_rdata,
    output cdq_stat_t                 stat
);

    cdq_state_t                state_reg, state_next;
    logic [IDX_W-1:0]          front_reg, front_next;
    logic [IDX_W-1:0]          rear_reg, rear_next;
    logic                      empty_reg, empty_next;
    logic [IDX_W-1:0]          scan_reg, scan_next;
    logic                      scan_done_reg, scan_done_next;
    logic                      pend_reg, pend_next;
    logic                      pend_last_reg, pend_last_next;
    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;

    logic             out_free;
    logic             fire;
    logic             full;
    logic [IDX_W-1:0] front_after, front_before, rear_after, rear_before, scan_after;

    function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] i,
                                                    input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] nxt;
        nxt = CAP_W'(i) + CAP_W'(1);
        return (nxt >= c) ? '0 : IDX_W'(nxt);
    endfunction

    function automatic logic [IDX_W-1:0] slot_before(input logic [IDX_W-1:0] i,
                                                     input logic [CAP_W-1:0] c);
        return (i == '0) ? IDX_W'(c - CAP_W'(1)) : IDX_W'(i - IDX_W'(1));
    endfunction

    assign front_after  = slot_after(front_reg, cap);
    assign front_before = slot_before(front_reg, cap);
    assign rear_after   = slot_after(rear_reg, cap);
    assign rear_before  = slot_before(rear_reg, cap);
    assign scan_after   = slot_after(scan_reg, cap);
    assign full         = !empty_reg && (rear_after == front_reg);

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_CMD) && out_free;
    assign fire         = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMD;
            front_reg     <= '0;
            rear_reg      <= '0;
            empty_reg     <= 1'b1;
            scan_reg      <= '0;
            scan_done_reg <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            empty_reg     <= empty_next;
            scan_reg      <= scan_next;
            scan_done_reg <= scan_done_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        empty_next      = empty_reg;
        scan_next       = scan_reg;
        scan_done_next  = scan_done_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = in_ch.push_value;
        mem_re          = 1'b0;
        mem_raddr       = front_reg;

        unique case (state_reg)
            ST_CMD:
            begin
                if (fire)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    unique case (in_ch.cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                        begin
                            if (full)
                            begin
                                out_status_next = STAT_OVERFLOW;
                            end
                            else if (empty_reg)
                            begin
                                front_next = '0;
                                rear_next  = '0;
                                empty_next = 1'b0;
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                            end
                            else if (in_ch.cmd == CMD_PUSH_FRONT)
                            begin
                                front_next = front_before;
                                mem_we     = 1'b1;
                                mem_waddr  = front_before;
                            end
                            else
                            begin
                                rear_next = rear_after;
                                mem_we    = 1'b1;
                                mem_waddr = rear_after;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR:
                        begin
                            if (empty_reg)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else if (front_reg == rear_reg)
                            begin
                                front_next = '0;
                                rear_next  = '0;
                                empty_next = 1'b1;
                            end
                            else if (in_ch.cmd == CMD_POP_FRONT)
                            begin
                                front_next = front_after;
                            end
                            else
                            begin
                                rear_next = rear_before;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (empty_reg)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // first element read now, beats come from ST_LIST
                                out_valid_next = 1'b0;
                                mem_re         = 1'b1;
                                mem_raddr      = front_reg;
                                pend_next      = 1'b1;
                                pend_last_next = (front_reg == rear_reg);
                                scan_done_next = (front_reg == rear_reg);
                                scan_next      = front_after;
                                state_next     = ST_LIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (pend_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_value_next  = mem_rdata;
                    out_last_next   = pend_last_reg;
                    if (!scan_done_reg)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = scan_reg;
                        pend_last_next = (scan_reg == rear_reg);
                        scan_done_next = (scan_reg == rear_reg);
                        scan_next      = scan_after;
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_CMD;
                    end
                end
            end
            default:
            begin
                state_next = ST_CMD;
            end
        endcase

        if (cfg_clear)
        begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.read_value = out_value_reg;
    assign out_ch.last       = out_last_reg;

    assign stat.listing = (state_reg == ST_LIST);
    assign stat.empty   = empty_reg;

endmodule

// ===== rtl/circular_deque_top.sv =====
`timescale 1ns / 1ps
// Push, pop and unused commands: one beat, registered, in the cycle after accept;
// one command per cycle while results are taken. List of n elements: n beats from
// the single memory read port, the first via the read and result registers, then
// one per cycle while results are taken; input stalls until the last beat loads.
// Reset: deque empty, capacity = DEPTH; ring contents undefined, no clearing pass.
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue in a ring memory with a writable capacity register.
// ----------------------------------------------------------------------------
`include "circular_deque_top_defines.svh"

module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    cdq_cmd_if.sink          in_ch,
    cdq_res_if.source        out_ch,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    logic [CAP_W-1:0]          cap_reg, cap_next;
    logic                      mem_we, mem_re;
    logic [IDX_W-1:0]          mem_waddr, mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata, mem_rdata;
    cdq_stat_t                 stat;

    // saturate the written capacity to 1..DEPTH
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
            begin
                cap_next = CAP_W'(1);
            end
            else if (cfg_wr_data > CAP_W'(DEPTH))
            begin
                cap_next = CAP_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(DEPTH);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cap       (cap_reg),
        .cfg_clear (cfg_wr_en),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .stat      (stat)
    );

    cdq_ring_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    `CDQ_ASSERT_NEXT(a_cfg_empties, cfg_wr_en, stat.empty, "capacity write did not empty deque")
    `CDQ_ASSERT_NOW(a_list_blocks, stat.listing, !in_ch.ready, "command taken during list")
    `CDQ_ASSERT_NOW(a_err_single, out_ch.valid && out_ch.status != STAT_OK, out_ch.last, "error result not last")
    `CDQ_ASSERT_NOW(a_cap_range, 1'b1, cap_reg != '0 && cap_reg <= CAP_W'(DEPTH), "capacity out of range")

endmodule
